/* rtl/dclpf_pkg.sv */
// Shared constants, tap table and types for the dual-channel low-pass FIR.
package dclpf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 16;
  localparam int TAP_COUNT = 51;
  localparam int TAP_IDX_W = $clog2(TAP_COUNT);
  localparam int PROD_W    = SAMPLE_W + COEF_W + 1;
  localparam int ACC_W     = PROD_W + $clog2(TAP_COUNT) + 1;
  localparam int DATA_W    = 4 * SAMPLE_W;

  localparam logic [COEF_W-1:0] TAPS [TAP_COUNT] = '{
    16'd0,    16'd11,   16'd25,   16'd46,   16'd78,   16'd122,  16'd182,  16'd261,
    16'd360,  16'd481,  16'd623,  16'd787,  16'd970,  16'd1169, 16'd1382, 16'd1603,
    16'd1828, 16'd2051, 16'd2266, 16'd2468, 16'd2649, 16'd2807, 16'd2934, 16'd3028,
    16'd3086, 16'd3105, 16'd3086, 16'd3028, 16'd2934, 16'd2807, 16'd2649, 16'd2468,
    16'd2266, 16'd2051, 16'd1828, 16'd1603, 16'd1382, 16'd1169, 16'd970,  16'd787,
    16'd623,  16'd481,  16'd360,  16'd261,  16'd182,  16'd122,  16'd78,   16'd46,
    16'd25,   16'd11,   16'd0
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ac_ir;
    logic signed [SAMPLE_W-1:0] ac_red;
  } pair_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

endpackage

/* rtl/dual_channel_lowpass_fir.sv */
// A request runs through the tap pass (ST_RUN), ST_DRAIN and ST_DONE before its result is loaded.
// A new request is taken only in ST_IDLE, once the 51-cell delay line has rotated for the last one.
// A new request is taken while the previous result waits at the output register.
// Reset clears both delay lines to zero and empties the output register.
// Top level of the dual-channel 51-tap low-pass FIR.
module dual_channel_lowpass_fir (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // ac_red, dc_red, ac_ir, dc_ir
  input  logic [dclpf_pkg::DATA_W-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // filtered_ac_red, dc_red_out, filtered_ac_ir, dc_ir_out
  output logic [dclpf_pkg::DATA_W-1:0]   m_axis_tdata
);
  import dclpf_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [TAP_IDX_W-1:0]   cnt_q, cnt_d;
  logic                   prod_vld_q;
  logic                   out_vld_q;
  logic [DATA_W-1:0]      out_data_q;
  logic [SAMPLE_W-1:0]    dc_red_q, dc_ir_q;
  logic                   in_acc, run, load_out, cell_en;
  pair_t                  chain [TAP_COUNT];
  pair_t                  head_d, new_pair;
  mac_ctrl_t              mac_ctrl;
  logic [COEF_W-1:0]      coef;
  logic signed [SAMPLE_W-1:0] res_red, res_ir;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign run           = (state_q == ST_RUN);
  assign load_out      = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);
  assign cell_en       = in_acc || run;

  assign new_pair.ac_red = s_axis_tdata[SAMPLE_W-1:0];
  assign new_pair.ac_ir  = s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
  assign head_d          = in_acc ? new_pair : chain[TAP_COUNT-1];

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
    if (k == 0) begin : g_head
      dclpf_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (cell_en),
        .d_i    (head_d),
        .q_o    (chain[k])
      );
    end else begin : g_body
      dclpf_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (cell_en),
        .d_i    (chain[k-1]),
        .q_o    (chain[k])
      );
    end
  end

  assign coef            = TAPS[cnt_q];
  assign mac_ctrl.clear  = in_acc;
  assign mac_ctrl.mul_en = run;
  assign mac_ctrl.acc_en = prod_vld_q;

  dclpf_mac u_mac_red (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (chain[TAP_COUNT-1].ac_red),
    .coef_i   (coef),
    .result_o (res_red)
  );

  dclpf_mac u_mac_ir (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (chain[TAP_COUNT-1].ac_ir),
    .coef_i   (coef),
    .result_o (res_ir)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        if (cnt_q == TAP_IDX_W'(TAP_COUNT - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      prod_vld_q <= run;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dc_red_q <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
      dc_ir_q  <= s_axis_tdata[4*SAMPLE_W-1:3*SAMPLE_W];
    end
    if (load_out) begin
      out_data_q <= {dc_ir_q, res_ir, dc_red_q, res_red};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run |-> (cnt_q < TAP_IDX_W'(TAP_COUNT)))
    else $error("tap counter out of range");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RUN) && (cnt_q == '0))
    else $error("request did not start a tap pass");

  a_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_vld_q |-> (state_q == ST_RUN) || (state_q == ST_DRAIN))
    else $error("product valid outside a tap pass");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result shown without finished pass");

endmodule

/* rtl/dclpf_cell.sv */
// One delay-line cell holding a red and an infrared sample.
module dclpf_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  dclpf_pkg::pair_t d_i,
  output dclpf_pkg::pair_t q_o
);
  import dclpf_pkg::*;

  pair_t sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (en_i) begin
      sample_q <= d_i;
    end
  end

  assign q_o = sample_q;

endmodule

/* rtl/dclpf_mac.sv */
// Multiply-accumulate unit with rounding and saturation for one channel.
module dclpf_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dclpf_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [dclpf_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [dclpf_pkg::COEF_W-1:0]         coef_i,
  output logic signed [dclpf_pkg::SAMPLE_W-1:0] result_o
);
  import dclpf_pkg::*;

  localparam int SH_W = ACC_W - COEF_FRAC;
  localparam logic signed [SH_W-1:0] SAT_HI =
    {{(SH_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SH_W-1:0] SAT_LO =
    {{(SH_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC - 1);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [SH_W-1:0]   sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      if (ctrl_i.mul_en) begin
        prod_q <= sample_i * $signed({1'b0, coef_i});
      end
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (ctrl_i.acc_en) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_comb begin
    rnd = acc_q + HALF;
    sh  = rnd[ACC_W-1:COEF_FRAC];
    if (sh > SAT_HI) begin
      result_o = SAT_HI[SAMPLE_W-1:0];
    end else if (sh < SAT_LO) begin
      result_o = SAT_LO[SAMPLE_W-1:0];
    end else begin
      result_o = sh[SAMPLE_W-1:0];
    end
  end

endmodule

/* tb/sv/tb_dual_channel_lowpass_fir.sv */
`timescale 1ns / 1ps
// Self-checking testbench that streams oximeter samples through the dual-channel FIR.
module tb_dual_channel_lowpass_fir;

  localparam int TAP_NUM        = 51;
  localparam int LATENCY_CYCLES = 54;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 900;

  localparam int unsigned LP_COEF [TAP_NUM] = '{
    0, 11, 25, 46, 78, 122, 182, 261, 360, 481,
    623, 787, 970, 1169, 1382, 1603, 1828, 2051, 2266, 2468,
    2649, 2807, 2934, 3028, 3086, 3105, 3086, 3028, 2934, 2807,
    2649, 2468, 2266, 2051, 1828, 1603, 1382, 1169, 970, 787,
    623, 481, 360, 261, 182, 122, 78, 46, 25, 11,
    0
  };

  typedef struct packed {
    logic signed [15:0] dc_ir;
    logic signed [15:0] ac_ir;
    logic signed [15:0] dc_red;
    logic signed [15:0] ac_red;
  } oxi_sample_t;

  typedef struct packed {
    logic signed [15:0] dc_ir_out;
    logic signed [15:0] filtered_ac_ir;
    logic signed [15:0] dc_red_out;
    logic signed [15:0] filtered_ac_red;
  } oxi_result_t;

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [dclpf_pkg::DATA_W-1:0] s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [dclpf_pkg::DATA_W-1:0] m_axis_tdata;

  logic signed [15:0] red_line [TAP_NUM] = '{default: '0};
  logic signed [15:0] ir_line  [TAP_NUM] = '{default: '0};
  oxi_result_t        pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int stall_req     = 0;
  int fail_count    = 0;
  int cycle_count   = 0;

  dual_channel_lowpass_fir dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [15:0] lowpass_output(input bit use_ir);
    longint acc;
    longint rounded;
    int     i;
    acc = 0;
    for (i = 0; i < TAP_NUM; i++) begin
      if (use_ir) begin
        acc += longint'(LP_COEF[i]) * longint'(ir_line[TAP_NUM-1-i]);
      end else begin
        acc += longint'(LP_COEF[i]) * longint'(red_line[TAP_NUM-1-i]);
      end
    end
    // Adding one half and shifting arithmetically rounds ties toward plus infinity.
    rounded = (acc + 64'sd32768) >>> 16;
    if (rounded > 32767) rounded = 32767;
    if (rounded < -32768) rounded = -32768;
    return rounded[15:0];
  endfunction

  task automatic predict_result(input oxi_sample_t smp);
    oxi_result_t res;
    int          i;
    for (i = TAP_NUM - 1; i > 0; i--) begin
      red_line[i] = red_line[i-1];
      ir_line[i]  = ir_line[i-1];
    end
    red_line[0] = smp.ac_red;
    ir_line[0]  = smp.ac_ir;
    res.filtered_ac_red = lowpass_output(1'b0);
    res.dc_red_out      = smp.dc_red;
    res.filtered_ac_ir  = lowpass_output(1'b1);
    res.dc_ir_out       = smp.dc_ir;
    pending_results.push_back(res);
  endtask

  function automatic oxi_sample_t make_sample(input int ac_red, input int dc_red,
                                              input int ac_ir, input int dc_ir);
    oxi_sample_t smp;
    smp.ac_red = ac_red[15:0];
    smp.dc_red = dc_red[15:0];
    smp.ac_ir  = ac_ir[15:0];
    smp.dc_ir  = dc_ir[15:0];
    return smp;
  endfunction

  task automatic send_sample(input oxi_sample_t smp);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= smp;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_result(smp);
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic compare_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_val), $signed(act_val));
      fail_count++;
    end
  endtask

  task automatic check_result(input oxi_result_t act);
    oxi_result_t exp_res;
    if (pending_results.size() == 0) begin
      $error("result %h arrived with no request outstanding", act);
      fail_count++;
    end else begin
      exp_res = pending_results.pop_front();
      compare_field("filtered_ac_red", exp_res.filtered_ac_red, act.filtered_ac_red);
      compare_field("dc_red_out", exp_res.dc_red_out, act.dc_red_out);
      compare_field("filtered_ac_ir", exp_res.filtered_ac_ir, act.filtered_ac_ir);
      compare_field("dc_ir_out", exp_res.dc_ir_out, act.dc_ir_out);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int stall_seen;
    stall_seen = 0;
    forever begin
      @(posedge clk_i);
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Extremes of every field, sign flips and bit patterns while the history still fills up.
  task automatic test_directed_extremes();
    send_idle_pct = 12;
    recv_idle_pct = 77;
    send_sample(make_sample(32767, -32768, -32768, 32767));
    repeat (4) send_sample(make_sample(0, 0, 0, 0));
    send_sample(make_sample(-32768, 32767, 32767, -32768));
    repeat (3) send_sample(make_sample(0, -1, 0, -1));
    send_sample(make_sample(-1, 1, 1, -1));
    send_sample(make_sample(1, -1, -1, 1));
    send_sample(make_sample('h5555, 'hAAAA, 'hAAAA, 'h5555));
    send_sample(make_sample('hAAAA, 'h5555, 'h5555, 'hAAAA));
    repeat (3) send_sample(make_sample(32767, 0, 32767, 0));
    repeat (3) send_sample(make_sample(-32768, 0, -32768, 0));
    send_sample(make_sample(0, 32767, 0, -32768));
  endtask

  function automatic oxi_sample_t shaped_sample(input int mode, input int idx,
                                                input int red_lvl, input int ir_lvl);
    oxi_sample_t smp;
    smp = {$urandom, $urandom};
    smp.dc_ir = 16'($urandom);
    case (mode)
      1: begin
        smp.ac_red = 16'($urandom_range(400, 0) - 200);
        smp.ac_ir  = 16'($urandom_range(400, 0) - 200);
      end
      2: begin
        smp.ac_red = red_lvl[15:0];
        smp.ac_ir  = ir_lvl[15:0];
      end
      3: begin
        smp.ac_red = idx[0] ? red_lvl[15:0] : ~red_lvl[15:0];
        smp.ac_ir  = idx[0] ? ir_lvl[15:0] : ~ir_lvl[15:0];
      end
      default: begin
      end
    endcase
    return smp;
  endfunction

  function automatic int pick_level();
    int roll;
    roll = $urandom_range(2, 0);
    if (roll == 0) return 32767;
    if (roll == 1) return -32768;
    return int'($signed(16'($urandom)));
  endfunction

  // Bursts of full-range noise, small signals, long steady levels that drive the
  // sums into saturation, and fast alternation that the filter should suppress.
  task automatic test_random_bursts(input int tx_pct, input int rx_pct, input int count);
    int sent;
    int roll;
    int mode;
    int burst;
    int red_lvl;
    int ir_lvl;
    int k;
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99, 0);
      mode = (roll < 40) ? 0 : (roll < 60) ? 1 : (roll < 85) ? 2 : 3;
      burst = (mode == 2) ? $urandom_range(110, 40) : $urandom_range(40, 1);
      red_lvl = pick_level();
      ir_lvl  = pick_level();
      for (k = 0; k < burst && sent < count; k++) begin
        send_sample(shaped_sample(mode, k, red_lvl, ir_lvl));
        sent++;
      end
    end
  endtask

  // The receiver stalls for a long stretch while requests keep coming, so the block fills up.
  task automatic test_output_stall();
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req++;
    for (k = 0; k < 20; k++) send_sample(shaped_sample(0, k, 0, 0));
  endtask

  // The sender goes quiet until every outstanding result has been delivered.
  task automatic test_sender_pause();
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 30;
    for (k = 0; k < 30; k++) send_sample(shaped_sample(0, k, 0, 0));
    s_axis_tvalid <= 1'b0;
    wait_for_results();
    @(posedge clk_i);
    for (k = 0; k < 30; k++) send_sample(shaped_sample(1, k, 0, 0));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_output_stall();
    test_random_bursts(12, 77, 360);
    test_sender_pause();
    test_random_bursts(77, 12, 360);
    test_random_bursts(0, 0, 360);
    s_axis_tvalid <= 1'b0;
    wait_for_results();
    repeat (LATENCY_CYCLES + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
